[design/bfs_pkg.sv]
// Shared types and constants for the BFS shortest-path block.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 512;

  localparam int NODE_W  = 6;
  localparam int ADDR_W  = 9;
  localparam int VALUE_W = 10;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic [1:0] REQ_ROW_OFFSET = 2'd0;
  localparam logic [1:0] REQ_EDGE       = 2'd1;
  localparam logic [1:0] REQ_QUERY      = 2'd2;

  typedef enum logic [1:0] {
    ST_PATH     = 2'd0,
    ST_NO_PATH  = 2'd1,
    ST_BAD_NODE = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  hops;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_ROW0,
    S_ROW1,
    S_ROW2,
    S_EDGE,
    S_NBR,
    S_WALK,
    S_WALKR,
    S_EMIT0,
    S_EMIT
  } state_t;

endpackage

[design/bfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bfs_engine.sv]
// Search sequencer: BFS queue walk, parent trace and path emission.
`timescale 1ns / 1ps

module bfs_engine #(
  parameter int MAX_NODES = bfs_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = bfs_pkg::DEF_MAX_EDGES,
  localparam int RAW = $clog2(MAX_NODES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [bfs_pkg::NODE_W-1:0]    src,
  input  logic [bfs_pkg::NODE_W-1:0]    dst,
  input  logic [bfs_pkg::COUNT_W-1:0]   n,
  output logic                          busy,
  output logic [RAW-1:0]                row_raddr,
  input  logic [bfs_pkg::VALUE_W-1:0]   row_rdata,
  output logic [EAW-1:0]                edge_raddr,
  input  logic [bfs_pkg::NODE_W:0]      edge_rdata,
  output logic                          res_valid,
  output bfs_pkg::result_t              res
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int QW = $clog2(MAX_NODES + 1);
  localparam int SW = $clog2(MAX_EDGES + 1);

  bfs_pkg::state_t state_r, state_nxt;

  logic [QW-1:0]        head_r, head_nxt;
  logic [QW-1:0]        tail_r, tail_nxt;
  logic [QW-1:0]        len_r, len_nxt;
  logic [NW-1:0]        node_r, node_nxt;
  logic [NW-1:0]        cur_r, cur_nxt;
  logic [NW-1:0]        idx_r, idx_nxt;
  logic [NW-1:0]        src_r, src_nxt;
  logic [NW-1:0]        dst_r, dst_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [SW-1:0]        end_r, end_nxt;
  logic                 found_r, found_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;

  logic          q_we, par_we, path_we;
  logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
  logic [NW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic [NW-1:0] path_waddr, path_wdata, path_raddr, path_rdata;

  logic                       range_bad;
  logic                       queue_more;
  logic [SW-1:0]              row_clamped;
  logic [bfs_pkg::NODE_W-1:0] nb;
  logic                       nb_bad;
  logic                       nb_take;

  assign range_bad  = ({1'b0, src} >= n) || ({1'b0, dst} >= n);
  assign queue_more = (head_r < tail_r) && !found_r;
  assign row_clamped = (32'(row_rdata) > MAX_EDGES) ? SW'(MAX_EDGES) : SW'(row_rdata);
  assign nb      = edge_rdata[bfs_pkg::NODE_W-1:0];
  assign nb_bad  = edge_rdata[bfs_pkg::NODE_W];
  assign nb_take = !nb_bad && ({1'b0, nb} < n) && !visited_r[nb[NW-1:0]];
  assign busy    = (state_r != bfs_pkg::S_IDLE);

  bfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  bfs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfs_pkg::S_IDLE: begin
        if (go && !range_bad) state_nxt = bfs_pkg::S_POP;
      end
      bfs_pkg::S_POP: begin
        if (queue_more)    state_nxt = bfs_pkg::S_ROW0;
        else if (!found_r) state_nxt = bfs_pkg::S_IDLE;
        else               state_nxt = bfs_pkg::S_WALK;
      end
      bfs_pkg::S_ROW0: state_nxt = bfs_pkg::S_ROW1;
      bfs_pkg::S_ROW1: state_nxt = bfs_pkg::S_ROW2;
      bfs_pkg::S_ROW2: state_nxt = bfs_pkg::S_EDGE;
      bfs_pkg::S_EDGE: begin
        state_nxt = (slot_r < end_r) ? bfs_pkg::S_NBR : bfs_pkg::S_POP;
      end
      bfs_pkg::S_NBR: state_nxt = bfs_pkg::S_EDGE;
      bfs_pkg::S_WALK: begin
        state_nxt = (cur_r == src_r) ? bfs_pkg::S_EMIT0 : bfs_pkg::S_WALKR;
      end
      bfs_pkg::S_WALKR: begin
        if (7'(par_rdata) >= n)      state_nxt = bfs_pkg::S_EMIT0;
        else if (7'(len_r) < n)      state_nxt = bfs_pkg::S_WALK;
        else                         state_nxt = bfs_pkg::S_EMIT0;
      end
      bfs_pkg::S_EMIT0: state_nxt = bfs_pkg::S_EMIT;
      bfs_pkg::S_EMIT: begin
        if (idx_r == '0) state_nxt = bfs_pkg::S_IDLE;
      end
      default: state_nxt = bfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    slot_nxt    = slot_r;
    end_nxt     = end_r;
    found_nxt   = found_r;
    visited_nxt = visited_r;
    q_we        = 1'b0;
    q_waddr     = '0;
    q_wdata     = '0;
    q_raddr     = '0;
    par_we      = 1'b0;
    par_waddr   = '0;
    par_wdata   = '0;
    par_raddr   = '0;
    path_we     = 1'b0;
    path_waddr  = '0;
    path_wdata  = '0;
    path_raddr  = '0;
    row_raddr   = '0;
    edge_raddr  = '0;
    res_valid   = 1'b0;
    res         = '0;
    unique case (state_r)
      bfs_pkg::S_IDLE: begin
        if (go) begin
          if (range_bad) begin
            res_valid  = 1'b1;
            res.status = bfs_pkg::ST_BAD_NODE;
            res.last   = 1'b1;
          end else begin
            src_nxt     = src[NW-1:0];
            dst_nxt     = dst[NW-1:0];
            found_nxt   = (src == dst);
            visited_nxt = '0;
            visited_nxt[src[NW-1:0]] = 1'b1;
            par_we      = 1'b1;
            par_waddr   = src[NW-1:0];
            par_wdata   = src[NW-1:0];
            q_we        = 1'b1;
            q_waddr     = '0;
            q_wdata     = src[NW-1:0];
            head_nxt    = '0;
            tail_nxt    = QW'(1);
          end
        end
      end
      bfs_pkg::S_POP: begin
        if (queue_more) begin
          q_raddr  = head_r[NW-1:0];
          head_nxt = head_r + 1'b1;
        end else if (!found_r) begin
          res_valid  = 1'b1;
          res.status = bfs_pkg::ST_NO_PATH;
          res.last   = 1'b1;
        end else begin
          len_nxt = '0;
          cur_nxt = dst_r;
        end
      end
      bfs_pkg::S_ROW0: begin
        node_nxt  = q_rdata;
        row_raddr = RAW'(q_rdata);
      end
      bfs_pkg::S_ROW1: begin
        slot_nxt  = row_clamped;
        row_raddr = RAW'(node_r) + 1'b1;
      end
      bfs_pkg::S_ROW2: begin
        end_nxt = row_clamped;
      end
      bfs_pkg::S_EDGE: begin
        if (slot_r < end_r) begin
          edge_raddr = slot_r[EAW-1:0];
          slot_nxt   = slot_r + 1'b1;
        end
      end
      bfs_pkg::S_NBR: begin
        if (nb_take) begin
          visited_nxt[nb[NW-1:0]] = 1'b1;
          par_we    = 1'b1;
          par_waddr = nb[NW-1:0];
          par_wdata = node_r;
          if (32'(tail_r) < MAX_NODES) begin
            q_we     = 1'b1;
            q_waddr  = tail_r[NW-1:0];
            q_wdata  = nb[NW-1:0];
            tail_nxt = tail_r + 1'b1;
          end
          if (nb[NW-1:0] == dst_r) found_nxt = 1'b1;
        end
      end
      bfs_pkg::S_WALK: begin
        path_we    = 1'b1;
        path_waddr = len_r[NW-1:0];
        path_wdata = cur_r;
        len_nxt    = len_r + 1'b1;
        par_raddr  = cur_r;
      end
      bfs_pkg::S_WALKR: begin
        cur_nxt = par_rdata;
      end
      bfs_pkg::S_EMIT0: begin
        path_raddr = NW'(len_r - 1'b1);
        idx_nxt    = NW'(len_r - 1'b1);
      end
      bfs_pkg::S_EMIT: begin
        res_valid  = 1'b1;
        res.status = bfs_pkg::ST_PATH;
        res.node   = bfs_pkg::NODE_W'(path_rdata);
        res.hops   = bfs_pkg::NODE_W'(len_r - 1'b1);
        res.last   = (idx_r == '0);
        if (idx_r != '0) begin
          path_raddr = idx_r - 1'b1;
          idx_nxt    = idx_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfs_pkg::S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      found_r   <= 1'b0;
      visited_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      found_r   <= found_nxt;
      visited_r <= visited_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    node_r <= node_nxt;
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    slot_r <= slot_nxt;
    end_r  <= end_nxt;
  end

`ifndef SYNTHESIS
  a_busy_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(go))
    else $error("search started without a query");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (32'(tail_r) <= MAX_NODES))
    else $error("queue pointers out of order");

  a_found_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && found_r) |-> visited_r[dst_r])
    else $error("target found but not marked visited");

  a_res_state: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == bfs_pkg::S_IDLE || state_r == bfs_pkg::S_POP ||
                   state_r == bfs_pkg::S_EMIT))
    else $error("result outside an emitting state");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfs_pkg::S_EMIT && idx_r != '0) |=> state_r == bfs_pkg::S_EMIT)
    else $error("path emission cut short");
`endif

endmodule

[design/bfs_shortest_path_csr.sv]
// Top level: CSR graph store, load decode, config register and result register.
`timescale 1ns / 1ps

// Channel   Transfer when               Ports
// input     start & !busy               in_req_type in_addr in_value in_source_node in_target_node
// result    out_valid (one cycle)       out_status out_path_node out_hops out_last
// config    cfg_valid & cfg_ready       cfg_node_count
//
// Loads leave busy low, so the next item may follow at once.
// A query holds busy while it dequeues each node and reads its row offsets, scans
// each edge slot, ends the search, traces each path node back through the parent
// RAM, sets up emission and emits each result; each RAM has a single read port.
// Each result leaves the output register in the cycle after the engine forms it.
// rst_n is synchronous; node_count resets to 64. Results cannot be stalled.

module bfs_shortest_path_csr #(
  parameter int MAX_NODES = bfs_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = bfs_pkg::DEF_MAX_EDGES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_req_type,
  input  logic [bfs_pkg::ADDR_W-1:0]   in_addr,
  input  logic [bfs_pkg::VALUE_W-1:0]  in_value,
  input  logic [bfs_pkg::NODE_W-1:0]   in_source_node,
  input  logic [bfs_pkg::NODE_W-1:0]   in_target_node,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [bfs_pkg::NODE_W-1:0]   out_path_node,
  output logic [bfs_pkg::NODE_W-1:0]   out_hops,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfs_pkg::COUNT_W-1:0]  cfg_node_count
);

  localparam int RAW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [bfs_pkg::COUNT_W-1:0] node_count_r;
  logic [bfs_pkg::COUNT_W-1:0] n_use;

  logic                          accept;
  logic                          row_we, edge_we, query_go;
  logic [RAW-1:0]                row_raddr;
  logic [bfs_pkg::VALUE_W-1:0]   row_rdata;
  logic [EAW-1:0]                edge_raddr;
  logic [bfs_pkg::NODE_W:0]      edge_rdata, edge_wdata;

  logic             res_valid;
  bfs_pkg::result_t res;
  logic             out_valid_r;
  bfs_pkg::result_t out_res_r;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    row_we   = 1'b0;
    edge_we  = 1'b0;
    query_go = 1'b0;
    unique case (in_req_type)
      bfs_pkg::REQ_ROW_OFFSET: row_we   = accept && (32'(in_addr) <= MAX_NODES);
      bfs_pkg::REQ_EDGE:       edge_we  = accept && (32'(in_addr) < MAX_EDGES);
      bfs_pkg::REQ_QUERY:      query_go = accept;
      default: begin
      end
    endcase
  end

  assign edge_wdata = {(32'(in_value) >= MAX_NODES), in_value[bfs_pkg::NODE_W-1:0]};

  always_comb begin
    if (node_count_r == '0) n_use = bfs_pkg::COUNT_W'(1);
    else if (32'(node_count_r) > MAX_NODES) n_use = bfs_pkg::COUNT_W'(MAX_NODES);
    else n_use = node_count_r;
  end

  bfs_ram #(.WIDTH(bfs_pkg::VALUE_W), .DEPTH(MAX_NODES + 1)) u_row_offsets (
    .clk(clk), .we(row_we), .waddr(in_addr[RAW-1:0]), .wdata(in_value),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  bfs_ram #(.WIDTH(bfs_pkg::NODE_W + 1), .DEPTH(MAX_EDGES)) u_edge_targets (
    .clk(clk), .we(edge_we), .waddr(EAW'(in_addr)), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  bfs_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (query_go),
    .src        (in_source_node),
    .dst        (in_target_node),
    .n          (n_use),
    .busy       (busy),
    .row_raddr  (row_raddr),
    .row_rdata  (row_rdata),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bfs_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) node_count_r <= cfg_node_count;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_path_node = out_res_r.node;
  assign out_hops      = out_res_r.hops;
  assign out_last      = out_res_r.last;

endmodule
